// ----- rtl/core/dfpwm_pkg.sv -----
package dfpwm_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_RISE_RATE        = 8'd0;
  localparam logic [7:0] CFG_FALL_RATE        = 8'd1;
  localparam logic [7:0] CFG_LOWPASS_STRENGTH = 8'd2;

  // Register reset values.
  localparam logic [7:0] RISE_RATE_RESET        = 8'd7;
  localparam logic [7:0] FALL_RATE_RESET        = 8'd20;
  localparam logic [7:0] LOWPASS_STRENGTH_RESET = 8'd100;

  // Targets, in the 10-bit signed domain of the approach unit.
  localparam logic signed [9:0] TARGET_HIGH   = 10'sd127;
  localparam logic signed [9:0] TARGET_LOW    = -10'sd128;
  localparam logic signed [9:0] STRENGTH_MAX  = 10'sd255;
  localparam logic signed [9:0] STRENGTH_MIN  = 10'sd0;

  // Rounding offset added before the divide by 256.
  localparam logic signed [17:0] ROUND_HALF = 18'sd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHARGE,
    ST_STRENGTH,
    ST_FILTER
  } state_t;

  // One request to the shared approach unit.
  typedef struct packed {
    logic signed [9:0] cur;
    logic signed [9:0] target;
    logic [7:0]        rate;
    logic              nudge;
  } appr_req_t;

endpackage

// ----- rtl/core/dfpwm_approach_unit.sv -----
module dfpwm_approach_unit
  import dfpwm_pkg::*;
(
  input  appr_req_t         req,
  output logic signed [9:0] result
);

  logic signed [9:0]  diff;
  logic signed [17:0] prod;
  logic signed [17:0] rounded;
  logic signed [9:0]  step;
  logic signed [9:0]  moved;

  // Move cur toward target by round(rate * (target - cur) / 256).
  always_comb begin
    diff    = req.target - req.cur;
    prod    = $signed({10'b0, req.rate}) * $signed({{8{diff[9]}}, diff});
    rounded = prod + ROUND_HALF;
    // Taking the upper bits floors, like an arithmetic shift.
    step    = rounded[17:8];
    moved   = req.cur + step;
  end

  // When nudge is set and rounding stalls the value short of its target, step it by one.
  always_comb begin
    result = moved;
    if (req.nudge && (moved == req.cur) && (moved != req.target)) begin
      result = diff[9] ? (moved - 10'sd1) : (moved + 10'sd1);
    end
  end

endmodule

// ----- rtl/core/dfpwm_audio_decoder_unit.sv -----
// DFPWM1a audio decoder.
// Input channel (in_valid/in_ready): one coded byte plus a restart flag per
// transfer. Bit 0 of the byte is decoded first; restart clears charge,
// strength, last target and filter level before that byte is decoded.
// Output channel (out_valid/out_ready): eight signed 8-bit samples per byte,
// with last set on the eighth.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 rise
// rate, 1 fall rate, 2 low-pass strength; other indexes are ignored. Write
// only while the decoder is idle.
// Sequencing: each sample takes three steps (charge, strength, low-pass
// filter) through the single shared approach unit. A byte holds the block
// until its eighth filter step is done, and only then does in_ready return.
// The first sample is registered after its charge, strength and filter steps.
// A finished sample waits in an output register; if the receiver stalls, the
// filter step of the next sample holds until that register is taken.
// Reset clears the decoder state and the output valid flag, loads the
// register defaults and leaves the block idle and ready.
module dfpwm_audio_decoder_unit
  import dfpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        coded_byte,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] sample,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  state_t state, state_next;

  logic [7:0]        rise_rate;
  logic [7:0]        fall_rate;
  logic [7:0]        lowpass_strength;
  logic signed [7:0] charge;
  logic signed [7:0] prev_charge;
  logic [7:0]        strength;
  logic              prev_high;
  logic signed [7:0] filtered_level;
  logic [7:0]        bits;
  logic [2:0]        bit_idx;

  logic              in_fire;
  logic              cur_high;
  logic              same;
  logic signed [8:0] charge_sum;
  logic signed [7:0] level;
  logic              out_free;
  appr_req_t         req;
  logic signed [9:0] appr_result;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cur_high  = bits[bit_idx];
  assign same      = (cur_high == prev_high);
  assign out_free  = !out_valid || out_ready;

  // Antijerk: on a bit change, average the new charge with the previous one.
  assign charge_sum = {charge[7], charge} + {prev_charge[7], prev_charge};
  assign level      = same ? charge : charge_sum[8:1];

  // Feed the shared approach unit according to the current step.
  always_comb begin
    req = '0;
    unique case (state)
      ST_CHARGE: begin
        req.cur    = {{2{charge[7]}}, charge};
        req.target = cur_high ? TARGET_HIGH : TARGET_LOW;
        req.rate   = strength;
        req.nudge  = 1'b1;
      end
      ST_STRENGTH: begin
        req.cur    = {2'b00, strength};
        req.target = same ? STRENGTH_MAX : STRENGTH_MIN;
        req.rate   = same ? rise_rate : fall_rate;
        req.nudge  = 1'b1;
      end
      ST_FILTER: begin
        req.cur    = {{2{filtered_level[7]}}, filtered_level};
        req.target = {{2{level[7]}}, level};
        req.rate   = lowpass_strength;
        req.nudge  = 1'b0;
      end
      ST_IDLE: begin
        req = '0;
      end
    endcase
  end

  dfpwm_approach_unit u_approach (
    .req    (req),
    .result (appr_result)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_fire) state_next = ST_CHARGE;
      ST_CHARGE:   state_next = ST_STRENGTH;
      ST_STRENGTH: state_next = ST_FILTER;
      ST_FILTER: begin
        if (out_free) begin
          state_next = (bit_idx == 3'd7) ? ST_IDLE : ST_CHARGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_rate        <= RISE_RATE_RESET;
      fall_rate        <= FALL_RATE_RESET;
      lowpass_strength <= LOWPASS_STRENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RISE_RATE)        rise_rate        <= cfg_data;
      if (cfg_index == CFG_FALL_RATE)        fall_rate        <= cfg_data;
      if (cfg_index == CFG_LOWPASS_STRENGTH) lowpass_strength <= cfg_data;
    end
  end

  // Decoder state, updated one step at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      charge         <= '0;
      strength       <= '0;
      prev_high      <= 1'b0;
      filtered_level <= '0;
      bit_idx        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            bit_idx <= '0;
            if (restart) begin
              charge         <= '0;
              strength       <= '0;
              prev_high      <= 1'b0;
              filtered_level <= '0;
            end
          end
        end
        ST_CHARGE: begin
          charge <= appr_result[7:0];
        end
        ST_STRENGTH: begin
          strength <= appr_result[7:0];
        end
        ST_FILTER: begin
          if (out_free) begin
            filtered_level <= appr_result[7:0];
            prev_high      <= cur_high;
            bit_idx        <= bit_idx + 3'd1;
          end
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bits <= coded_byte;
    end
    if (state == ST_CHARGE) begin
      prev_charge <= charge;
    end
    if ((state == ST_FILTER) && out_free) begin
      sample <= appr_result[7:0];
      last   <= (bit_idx == 3'd7);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FILTER) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted byte starts decoding at its first bit.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CHARGE) && (bit_idx == 3'd0))
    else $error("decode did not start at bit 0");

  // The charge never moves away from a positive target.
  a_charge_dir: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHARGE) && cur_high |=> charge >= $past(charge))
    else $error("charge moved away from the high target");

  // A stalled output register holds the filter step.
  a_filter_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILTER) && out_valid && !out_ready
      |=> (state == ST_FILTER) && $stable(filtered_level) && $stable(bit_idx))
    else $error("filter advanced while output was stalled");

  // The last flag is set only with the eighth sample.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILTER) && out_free |=> (last == ($past(bit_idx) == 3'd7)))
    else $error("last flag on the wrong sample");

endmodule
